// ===== rtl/rpi_pkg.sv =====
// ----------------------------------------------------------------------------
// rpi_pkg: shared types and constants for the ray/plane intersect core
// Fixed-point format, request/result structs and the divider stage record.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;

  // Derived widths
  localparam int ProdWidth = 2 * CoordWidth;           // exact product
  localparam int DotWidth  = ProdWidth + 2;            // sum of three products
  localparam int OffWidth  = CoordWidth + FracBits;    // offset aligned to products
  localparam int NumWidth  = ((OffWidth > DotWidth) ? OffWidth : DotWidth) + 1;
  localparam int QuoWidth  = CoordWidth - 1;           // hit distance width
  localparam int DivdWidth = NumWidth + FracBits;      // dividend |num| << FracBits
  localparam int RemWidth  = (DivdWidth > DotWidth + QuoWidth) ?
                             DivdWidth : DotWidth + QuoWidth;

  typedef enum logic [1:0] {
    StHit     = 2'd0,
    StMiss    = 2'd1,
    StInPlane = 2'd2
  } hit_status_e;

  typedef enum logic [1:0] {
    RegNormalX     = 2'd0,
    RegNormalY     = 2'd1,
    RegNormalZ     = 2'd2,
    RegPlaneOffset = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] origin_x;
    logic signed [CoordWidth-1:0] origin_y;
    logic signed [CoordWidth-1:0] origin_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
  } ray_req_t;

  typedef struct packed {
    logic [QuoWidth-1:0] hit_distance;
    logic [1:0]          hit_status;
  } ray_rsp_t;

  typedef struct packed {
    logic [RemWidth-1:0] rem;
    logic [DotWidth-1:0] den_mag;
    logic [QuoWidth-1:0] quo;
    logic                sat;
    hit_status_e         status;
  } div_stage_t;

endpackage

// ===== rtl/rpi_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rpi_div_pipe: pipelined restoring divider
// One quotient bit per stage, MSB first; the whole pipe advances on en_i.
// ----------------------------------------------------------------------------
module rpi_div_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rpi_pkg::div_stage_t stage_i,
  output logic                valid_o,
  output rpi_pkg::div_stage_t stage_o
);
  import rpi_pkg::*;

  div_stage_t          stg [QuoWidth+1];
  logic [QuoWidth:0]   vld;

  assign stg[0] = stage_i;
  assign vld[0] = valid_i;

  for (genvar k = 0; k < QuoWidth; k++) begin : g_stage
    localparam int Bit = QuoWidth - 1 - k;
    logic [RemWidth-1:0] cand;
    div_stage_t          nxt_d;
    div_stage_t          stg_q;
    logic                vld_q;

    always_comb begin
      cand  = RemWidth'(stg[k].den_mag) << Bit;
      nxt_d = stg[k];
      if (stg[k].rem >= cand) begin
        nxt_d.rem      = stg[k].rem - cand;
        nxt_d.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q <= nxt_d;
      end
    end

    assign stg[k+1] = stg_q;
    assign vld[k+1] = vld_q;
  end

  assign valid_o = vld[QuoWidth];
  assign stage_o = stg[QuoWidth];

endmodule

// ===== rtl/ray_plane_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_plane_intersect_core: fixed-point ray/plane intersection
// Dot products, classification and a pipelined divide for the ray parameter.
// ----------------------------------------------------------------------------
// Accepts one ray request per cycle unless a result waits at the output, and
// returns one result per request, in order, through one stage of six parallel
// multipliers, one of dot-product sums, one of sign/magnitude classification,
// one of saturation check, one divider stage per quotient bit and an output
// register. The whole pipeline freezes while a result waits on out_ready_i, so
// nothing is dropped or repeated. Plane registers are written through the cfg
// port and must only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module ray_plane_intersect_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // plane configuration
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_addr_i,
  input  logic [rpi_pkg::CoordWidth-1:0]      cfg_wdata_i,
  // ray requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rpi_pkg::ray_req_t                   in_req_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rpi_pkg::ray_rsp_t                   out_rsp_o
);
  import rpi_pkg::*;

  // --- plane registers ---
  logic signed [CoordWidth-1:0] nx_q, ny_q, nz_q, off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q  <= '0;
      ny_q  <= '0;
      nz_q  <= CoordWidth'(1) << FracBits;
      off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        RegNormalX:     nx_q  <= cfg_wdata_i;
        RegNormalY:     ny_q  <= cfg_wdata_i;
        RegNormalZ:     nz_q  <= cfg_wdata_i;
        RegPlaneOffset: off_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless the output holds an untaken result.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // --- stage 1: products ---
  logic                        v1_q;
  logic signed [ProdWidth-1:0] po_x_q, po_y_q, po_z_q, pd_x_q, pd_y_q, pd_z_q;
  logic signed [OffWidth-1:0]  off_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      po_x_q   <= in_req_i.origin_x * nx_q;
      po_y_q   <= in_req_i.origin_y * ny_q;
      po_z_q   <= in_req_i.origin_z * nz_q;
      pd_x_q   <= in_req_i.dir_x * nx_q;
      pd_y_q   <= in_req_i.dir_y * ny_q;
      pd_z_q   <= in_req_i.dir_z * nz_q;
      off_sh_q <= $signed({off_q, {FracBits{1'b0}}});
    end
  end

  // --- stage 2: num = d<<F - origin.n, den = dir.n ---
  logic                        v2_q;
  logic signed [NumWidth-1:0]  num_q;
  logic signed [DotWidth-1:0]  den_q;
  logic signed [DotWidth-1:0]  dot_o;

  assign dot_o = DotWidth'(po_x_q) + DotWidth'(po_y_q) + DotWidth'(po_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= NumWidth'(off_sh_q) - NumWidth'(dot_o);
      den_q <= DotWidth'(pd_x_q) + DotWidth'(pd_y_q) + DotWidth'(pd_z_q);
    end
  end

  // --- stage 3: classify and take magnitudes ---
  logic                v3_q;
  logic [NumWidth-1:0] num_mag_q;
  logic [DotWidth-1:0] den_mag_q;
  hit_status_e         st3_q;
  hit_status_e         st3_d;
  logic                num_zero, den_zero, num_neg, den_neg;

  assign num_zero = (num_q == '0);
  assign den_zero = (den_q == '0);
  assign num_neg  = num_q[NumWidth-1];
  assign den_neg  = den_q[DotWidth-1];

  always_comb begin
    if (num_zero && den_zero)                         st3_d = StInPlane;
    else if (num_zero || den_zero || num_neg != den_neg) st3_d = StMiss;
    else                                              st3_d = StHit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_mag_q <= num_neg ? NumWidth'(-num_q) : NumWidth'(num_q);
      den_mag_q <= den_neg ? DotWidth'(-den_q) : DotWidth'(den_q);
      st3_q     <= st3_d;
    end
  end

  // --- stage 4: saturation check, divider load ---
  // t saturates when |num|<<F >= |den|<<QuoWidth; otherwise t fits in QuoWidth bits.
  logic                v4_q;
  div_stage_t          div_in_q;
  logic [RemWidth-1:0] dvd, sat_lim;

  assign dvd     = RemWidth'({num_mag_q, {FracBits{1'b0}}});
  assign sat_lim = RemWidth'(den_mag_q) << QuoWidth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_in_q.rem     <= dvd;
      div_in_q.den_mag <= den_mag_q;
      div_in_q.quo     <= '0;
      div_in_q.sat     <= (dvd >= sat_lim);
      div_in_q.status  <= st3_q;
    end
  end

  // --- divider ---
  logic       div_valid;
  div_stage_t div_out;

  rpi_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .stage_i (div_in_q),
    .valid_o (div_valid),
    .stage_o (div_out)
  );

  // --- output register ---
  ray_rsp_t out_d, out_q;

  always_comb begin
    out_d.hit_status = div_out.status;
    if (div_out.status != StHit) out_d.hit_distance = '0;
    else if (div_out.sat)        out_d.hit_distance = '1;
    else                         out_d.hit_distance = div_out.quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= div_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // --- assertions ---
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted request did not enter stage 1");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.hit_status != StHit) |-> (out_rsp_o.hit_distance == '0))
    else $error("non-hit result with nonzero distance");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.hit_status != 2'd3))
    else $error("illegal status code");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(v4_q)))
    else $error("pipeline moved during output stall");

endmodule

// ===== test/ray_plane_checker.sv =====
// ----------------------------------------------------------------------------
// ray_plane_checker: result predictor and scoreboard for the intersect core
// Mirrors the plane registers, predicts each accepted ray request and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_plane_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_addr_i,
  input  logic [rpi_pkg::CoordWidth-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  rpi_pkg::ray_req_t              in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  rpi_pkg::ray_rsp_t              out_rsp_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rpi_pkg::*;

  logic signed [CoordWidth-1:0] plane_nx, plane_ny, plane_nz, plane_d;
  ray_rsp_t hits_q[$];

  assign pending_o = hits_q.size();

  function automatic ray_rsp_t predict_hit(ray_req_t r);
    logic signed [127:0] num, den, q;
    logic [127:0] mn, md;
    ray_rsp_t rsp;
    num = ($signed(plane_d) <<< FracBits) - (r.origin_x * plane_nx
          + $signed(128'(r.origin_y)) * plane_ny + $signed(128'(r.origin_z)) * plane_nz);
    den = $signed(128'(r.dir_x)) * plane_nx + $signed(128'(r.dir_y)) * plane_ny
          + $signed(128'(r.dir_z)) * plane_nz;
    rsp = '0;
    if (num == 0 && den == 0) begin
      rsp.hit_status = StInPlane;
    end else if (den == 0 || num == 0 || (num < 0) != (den < 0)) begin
      rsp.hit_status = StMiss;
    end else begin
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      q = (mn << FracBits) / md;
      rsp.hit_distance = (q > {QuoWidth{1'b1}}) ? {QuoWidth{1'b1}} : q[QuoWidth-1:0];
      rsp.hit_status = StHit;
    end
    return rsp;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ray_rsp_t want;
    if (!rst_ni) begin
      plane_nx <= '0;
      plane_ny <= '0;
      plane_nz <= CoordWidth'(1) << FracBits;
      plane_d <= '0;
      fail_count_o <= 0;
      hits_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          RegNormalX:     plane_nx <= cfg_wdata_i;
          RegNormalY:     plane_ny <= cfg_wdata_i;
          RegNormalZ:     plane_nz <= cfg_wdata_i;
          RegPlaneOffset: plane_d <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) hits_q.push_back(predict_hit(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (hits_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = hits_q.pop_front();
          if (want.hit_distance !== out_rsp_i.hit_distance ||
              want.hit_status !== out_rsp_i.hit_status) begin
            $display("%0t: mismatch: expected dist %h status %0d, actual dist %h status %0d",
                     $time, want.hit_distance, want.hit_status,
                     out_rsp_i.hit_distance, out_rsp_i.hit_status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression for the ray/plane intersect core
// Walks several plane settings (reset, unit axes, extremes, random), sends
// directed and random rays with random idling on both channels and lets
// the checker score every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpi_pkg::*;

  localparam int Latency = QuoWidth + 5;
  localparam int WatchdogLimit = 20000;
  localparam int One = 1 << FracBits;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [CoordWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ray_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ray_rsp_t out_rsp_o;
  int fail_count, pending, idle_cycles;
  bit quiet_phase;       // no idling near the end of the run

  always #5 clk_i = ~clk_i;

  ray_plane_intersect_core u_dut (.*);

  ray_plane_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: cycles without any request or result moving.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("ray_plane_intersect_core regression: fail");
        $finish;
      end
    end
  end

  // Result side: stall in random bursts, none in the quiet phase.
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (burst) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CoordWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_plane(logic [CoordWidth-1:0] nx, ny, nz, d);
    write_reg(RegNormalX, nx);
    write_reg(RegNormalY, ny);
    write_reg(RegNormalZ, nz);
    write_reg(RegPlaneOffset, d);
  endtask

  // Drain every pending result before the plane changes.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
  endtask

  // Sender is left at a falling edge; valid stays high across back-to-back requests.
  task automatic send_ray(ray_req_t r);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [CoordWidth-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return CoordWidth'($signed($urandom_range(0, 40 * One)) - 20 * One);
      2: return CoordWidth'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  function automatic ray_req_t rand_ray();
    ray_req_t r;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
    r.origin_x = rand_coord(mode);
    r.origin_y = rand_coord(mode);
    r.origin_z = rand_coord(mode);
    r.dir_x = rand_coord(mode);
    r.dir_y = rand_coord(mode);
    r.dir_z = rand_coord(mode);
    // sometimes zero components to hit parallel and in-plane cases
    if ($urandom_range(0, 7) == 0) r.dir_z = '0;
    if ($urandom_range(0, 9) == 0) r.origin_z = '0;
    return r;
  endfunction

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset plane z = 0 with normal +z.
    send_ray('{0, 0, 0, 0, 0, 0});                              // in plane
    send_ray('{0, 0, One, 0, 0, One});                          // parallel-free miss
    send_ray('{0, 0, One, One, 0, 0});                          // parallel
    send_ray('{0, 0, -One, 0, 0, One});                         // hit t = 1
    send_ray('{0, 0, 2 * One, 0, 0, -One});                     // hit t = 2
    send_ray('{0, 0, -One, 0, 0, 32'h7fff_ffff});               // tiny t
    send_ray('{0, 0, 32'h8000_0000, 0, 0, 1});                  // saturate
    send_ray('{0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000});
    send_ray('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_ray('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_ray('{0, 0, 0, 0, 0, 1});                              // origin on plane
    in_valid_i <= 1'b0;
    drain();

    // Extreme normals and offsets.
    set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    for (int i = 0; i < 6; i++) send_ray(rand_ray());
    send_ray('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    in_valid_i <= 1'b0;
    drain();
    set_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 6; i++) send_ray(rand_ray());
    in_valid_i <= 1'b0;
    drain();

    // Random phases with random planes; the last phase is idle-free.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet_phase = 1'b1;
      case (ph % 4)
        0: set_plane(One, 0, 0, $urandom());
        1: set_plane(0, -One, 0, rand_coord(1));
        2: set_plane('0, '0, '0, '0);
        default: set_plane($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      for (int i = 0; i < 105; i++) send_ray(rand_ray());
      in_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("ray_plane_intersect_core regression: pass");
    end else begin
      $display("ray_plane_intersect_core regression: fail");
    end
    $finish;
  end
endmodule
